// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps

package ffba_pkg;

  // Request and result field widths
  localparam int ADDR_W = 10;
  localparam int LEN_W  = 11;

  // Bitmap word: units per RAM row
  localparam int WORD_BITS = 8;
  localparam int WORD_SH   = $clog2(WORD_BITS);

  localparam int MEM_UNITS_DEF = 1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

endpackage

// ===== src/ffba_bitmap.sv =====
`timescale 1ns / 1ps

module ffba_bitmap #(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ROW_W-1:0]               waddr_i,
  input  logic [ffba_pkg::WORD_BITS-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [ROW_W-1:0]               raddr_i,
  output logic [ffba_pkg::WORD_BITS-1:0] rdata_o
);
  import ffba_pkg::*;

  logic [WORD_BITS-1:0] mem_q [ROWS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ffba_scan.sv =====
`timescale 1ns / 1ps

// Walks one bitmap word, extending the free-run count unit by unit.
module ffba_scan #(
  parameter int MEMORY_UNITS = 1024,
  parameter int RC_W         = 8,
  parameter int CW           = 12
) (
  input  logic [ffba_pkg::WORD_BITS-1:0] word_i,
  input  logic [RC_W-1:0]                row_i,
  input  logic [CW-1:0]                  run_i,
  input  logic [CW-1:0]                  len_i,
  output logic                           found_o,
  output logic [CW-1:0]                  start_o,
  output logic [CW-1:0]                  run_o
);
  import ffba_pkg::*;

  logic [CW-1:0] run;
  logic [CW-1:0] idx;
  logic          unit_free;

  always_comb begin
    run     = run_i;
    found_o = 1'b0;
    start_o = '0;
    idx     = '0;
    unit_free = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx       = CW'({row_i, WORD_SH'(j)});
      // units past the end of memory count as used
      unit_free = !word_i[j] && (idx < CW'(MEMORY_UNITS));
      run       = unit_free ? run + 1'b1 : '0;
      if (!found_o && (run == len_i)) begin
        found_o = 1'b1;
        start_o = idx + 1'b1 - len_i;
      end
    end
    run_o = run;
  end

endmodule

// ===== src/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps
// Allocate: scans 8-unit bitmap rows up to the end of the first run that fits, then marks the
//   rows that run touches; if no run fits, every row is scanned and failure is reported.
// Free: clears the rows the run touches; zero-length or oversize allocate, empty free: straight to result.
// One request at a time: the next is taken the cycle after its result loads; rate is set by
//   the bitmap RAM reading one 8-unit row a cycle and a held result stalls the last step.
// Reset: a clearing pass over all ceil(MEMORY_UNITS/8) rows zeroes the bitmap, in_ready_o low.
module first_fit_block_allocator_top #(
  parameter int MEMORY_UNITS = ffba_pkg::MEM_UNITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [ffba_pkg::LEN_W-1:0]  run_length_i,
  input  logic [ffba_pkg::ADDR_W-1:0] start_address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [ffba_pkg::ADDR_W-1:0] granted_address_o
);
  import ffba_pkg::*;

  localparam int ROWS  = (MEMORY_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W  = $clog2(ROWS + 1);
  localparam int CNT_W = $clog2(MEMORY_UNITS + 1);
  localparam int CW0   = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;
  localparam int CW    = (CW0 > RC_W + WORD_SH) ? CW0 : RC_W + WORD_SH;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [RC_W-1:0]     row_q;
  logic [RC_W-1:0]     pend_row_q;
  logic                pend_q;
  logic [CW-1:0]       run_q;
  logic [CW-1:0]       len_q;
  logic [CW-1:0]       lo_q;
  logic [CW-1:0]       hi_q;
  logic                set_q;
  logic                res_ok_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic                out_valid_q;
  logic                ok_q;
  logic [ADDR_W-1:0]   granted_q;

  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [WORD_BITS-1:0] mask;
  logic [CW-1:0]        unit_idx;

  logic                 scan_found;
  logic [CW-1:0]        scan_start;
  logic [CW-1:0]        scan_run;

  logic                 in_xfer;
  logic [CW-1:0]        req_len;
  logic [CW-1:0]        req_lo;
  logic [CW-1:0]        req_sum;
  logic [CW-1:0]        req_hi;
  logic                 scan_issue;
  logic                 mark_issue;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign req_len = CW'(run_length_i);
  assign req_lo  = CW'(start_address_i);
  assign req_sum = req_lo + req_len;
  assign req_hi  = (req_sum > CW'(MEMORY_UNITS)) ? CW'(MEMORY_UNITS) : req_sum;

  assign scan_issue = (state_q == ST_SCAN) && (row_q < RC_W'(ROWS));
  assign mark_issue = (state_q == ST_MARK) && (CW'({row_q, WORD_SH'(0)}) < hi_q);

  // Units of the pending row that fall inside [lo, hi)
  always_comb begin
    mask     = '0;
    unit_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      unit_idx = CW'({pend_row_q, WORD_SH'(j)});
      mask[j]  = (unit_idx >= lo_q) && (unit_idx < hi_q);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_row_q[ROW_W-1:0];
    mem_wdata = set_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
    mem_re    = scan_issue || mark_issue;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = row_q[ROW_W-1:0];
      mem_wdata = '0;
    end else if ((state_q == ST_MARK) && pend_q) begin
      mem_we = 1'b1;
    end
  end

  ffba_bitmap #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (row_q[ROW_W-1:0]),
    .rdata_o (mem_rdata)
  );

  ffba_scan #(
    .MEMORY_UNITS (MEMORY_UNITS),
    .RC_W         (RC_W),
    .CW           (CW)
  ) u_scan (
    .word_i  (mem_rdata),
    .row_i   (pend_row_q),
    .run_i   (run_q),
    .len_i   (len_q),
    .found_o (scan_found),
    .start_o (scan_start),
    .run_o   (scan_run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      pend_row_q  <= '0;
      pend_q      <= 1'b0;
      run_q       <= '0;
      len_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      set_q       <= 1'b0;
      res_ok_q    <= 1'b0;
      res_addr_q  <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      granted_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          row_q <= row_q + 1'b1;
          if (row_q == RC_W'(ROWS - 1)) begin
            row_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            res_addr_q <= '0;
            pend_q     <= 1'b0;
            if (op_e'(op_i) == OP_ALLOC) begin
              len_q <= req_len;
              set_q <= 1'b1;
              if (req_len == '0) begin
                res_ok_q <= 1'b1;
                state_q  <= ST_DONE;
              end else if (req_len > CW'(MEMORY_UNITS)) begin
                res_ok_q <= 1'b0;
                state_q  <= ST_DONE;
              end else begin
                row_q   <= '0;
                run_q   <= '0;
                state_q <= ST_SCAN;
              end
            end else begin
              res_ok_q <= 1'b1;
              set_q    <= 1'b0;
              lo_q     <= req_lo;
              hi_q     <= req_hi;
              row_q    <= RC_W'(req_lo >> WORD_SH);
              state_q  <= (req_lo < req_hi) ? ST_MARK : ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            row_q      <= row_q + 1'b1;
            pend_row_q <= row_q;
            pend_q     <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            run_q <= scan_run;
            if (scan_found) begin
              // switch to marking the granted run; drop the read in flight
              lo_q       <= scan_start;
              hi_q       <= scan_start + len_q;
              res_ok_q   <= 1'b1;
              res_addr_q <= scan_start[ADDR_W-1:0];
              row_q      <= RC_W'(scan_start >> WORD_SH);
              pend_q     <= 1'b0;
              state_q    <= ST_MARK;
            end else if (pend_row_q == RC_W'(ROWS - 1)) begin
              res_ok_q   <= 1'b0;
              res_addr_q <= '0;
              pend_q     <= 1'b0;
              state_q    <= ST_DONE;
            end
          end
        end
        ST_MARK: begin
          if (mark_issue) begin
            row_q      <= row_q + 1'b1;
            pend_row_q <= row_q;
            pend_q     <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            ok_q        <= res_ok_q;
            granted_q   <= res_addr_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign granted_address_o = granted_q;

endmodule

// ===== src/ffba_checker.sv =====
`timescale 1ns / 1ps

module ffba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        op_i,
  input logic [ffba_pkg::LEN_W-1:0]  run_length_i,
  input logic [ffba_pkg::ADDR_W-1:0] start_address_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        ok_i,
  input logic [ffba_pkg::ADDR_W-1:0] granted_address_i
);
  import ffba_pkg::*;

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) && $stable(granted_address_i))
    else $error("result changed while stalled");

  // A failed allocation reports address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> granted_address_i == '0)
    else $error("failure with nonzero address");

  // One request in flight: busy right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // A free's result is not loaded on the transfer itself (every free succeeds at address zero)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (op_e'(op_i) == OP_FREE) && !out_valid_i
    |=> !out_valid_i)
    else $error("result appeared too early");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_i        (in_ready_o),
  .op_i              (op_i),
  .run_length_i      (run_length_i),
  .start_address_i   (start_address_i),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .ok_i              (ok_o),
  .granted_address_i (granted_address_o)
);
